// File: rtl/pqwt_pkg.sv
// Package for the priority queue with wait time block.
// Holds sizes, operation codes and the controller/datapath interface structs.
`default_nettype none
package pqwt_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 16;
  localparam int PRIO_BITS   = 8;
  localparam int WAIT_W      = 20;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic push_ok;
    logic scan_done;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/priority_queue_with_wait_time_top.sv
// Top level of the priority queue with wait time block.
// Instantiates pqwt_ctrl and pqwt_dp; uses pqwt_pkg.
//
// A command transfer happens when start is high and busy is low. For pop,
// peek, unknown codes and pushes refused on a full queue, the result strobes
// on out_valid in the next cycle and busy stays low. An accepted push scans
// the queue one slot per cycle through a single slot read port up to its
// insert position (0 to occupancy); busy is high during the scan, up to and
// including the slot insert, and the result strobes in the cycle after the
// slot insert, when the next transfer can already be taken. The receiver
// cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module priority_queue_with_wait_time_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [1:0]                     in_operation,
  input  wire logic [pqwt_pkg::TIME_BITS-1:0] in_service_time,
  input  wire logic [pqwt_pkg::PRIO_BITS-1:0] in_priority_req,
  output logic                                out_valid,
  output logic [pqwt_pkg::WAIT_W-1:0]         out_wait_time,
  output logic [pqwt_pkg::TIME_BITS-1:0]      out_head_time,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic                                out_dropped
);

  pqwt_pkg::cmd_t    cmd;
  pqwt_pkg::status_t status;

  pqwt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  pqwt_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_operation    (in_operation),
    .in_service_time (in_service_time),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_wait_time   (out_wait_time),
    .out_head_time   (out_head_time),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_dropped     (out_dropped)
  );

endmodule
`default_nettype wire

// File: rtl/pqwt_ctrl.sv
// Controller: sequences the push scan over the queue slots.
// Depends on pqwt_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none
module pqwt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire pqwt_pkg::status_t status,
  output pqwt_pkg::cmd_t       cmd,
  output logic                 busy
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd.accept = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (status.push_ok) state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == ST_SCAN);

endmodule
`default_nettype wire

// File: rtl/pqwt_dp.sv
// Datapath: slot registers, occupancy, scan index, wait accumulator, result register.
// Depends on pqwt_pkg; commanded by pqwt_ctrl.
`default_nettype none
module pqwt_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pqwt_pkg::cmd_t                 cmd,
  output pqwt_pkg::status_t                   status,
  input  wire logic [1:0]                     in_operation,
  input  wire logic [pqwt_pkg::TIME_BITS-1:0] in_service_time,
  input  wire logic [pqwt_pkg::PRIO_BITS-1:0] in_priority_req,
  output logic                                out_valid,
  output logic [pqwt_pkg::WAIT_W-1:0]         out_wait_time,
  output logic [pqwt_pkg::TIME_BITS-1:0]      out_head_time,
  output logic                                out_is_empty,
  output logic                                out_is_full,
  output logic                                out_dropped
);

  logic [pqwt_pkg::TIME_BITS-1:0] slot_time_r [pqwt_pkg::QUEUE_DEPTH];
  logic [pqwt_pkg::PRIO_BITS-1:0] slot_prio_r [pqwt_pkg::QUEUE_DEPTH];
  logic [pqwt_pkg::OCC_W-1:0]     occ_r;
  logic [pqwt_pkg::IDX_W-1:0]     idx_r;
  logic [pqwt_pkg::WAIT_W-1:0]    acc_r, acc_nxt;
  logic                           hb_r;
  logic [pqwt_pkg::TIME_BITS-1:0] t_r;
  logic [pqwt_pkg::PRIO_BITS-1:0] p_r;
  logic                           out_valid_r;
  logic [pqwt_pkg::WAIT_W-1:0]    out_wait_r;
  logic [pqwt_pkg::TIME_BITS-1:0] out_head_r;
  logic                           out_empty_r, out_full_r, out_drop_r;

  logic                           q_empty, q_full;
  logic [pqwt_pkg::TIME_BITS-1:0] cur_time;
  logic [pqwt_pkg::PRIO_BITS-1:0] cur_prio;
  logic [pqwt_pkg::WAIT_W:0]      sum_w;
  logic [pqwt_pkg::OCC_W-1:0]     occ_inc;

  assign q_empty  = (occ_r == '0);
  assign q_full   = (occ_r == pqwt_pkg::OCC_W'(pqwt_pkg::QUEUE_DEPTH));
  assign cur_time = slot_time_r[idx_r];
  assign cur_prio = slot_prio_r[idx_r];
  assign occ_inc  = occ_r + pqwt_pkg::OCC_W'(1);

  assign status.push_ok   = (in_operation == pqwt_pkg::OP_PUSH) && !q_full;
  assign status.scan_done = (pqwt_pkg::OCC_W'(idx_r) == occ_r) ||
                            ((idx_r != '0) && (hb_r || (p_r < cur_prio)));

  assign sum_w   = {1'b0, acc_r} + (pqwt_pkg::WAIT_W + 1)'(cur_time);
  assign acc_nxt = sum_w[pqwt_pkg::WAIT_W] ? pqwt_pkg::WAIT_MAX
                                           : sum_w[pqwt_pkg::WAIT_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.accept && !status.push_ok) || cmd.finish;
      if (cmd.accept) begin
        if (in_operation == pqwt_pkg::OP_POP && !q_empty) begin
          occ_r <= occ_r - pqwt_pkg::OCC_W'(1);
        end
      end else if (cmd.finish) begin
        occ_r <= occ_inc;
      end
    end
  end

  // scan, slots and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_r   <= in_service_time;
      p_r   <= in_priority_req;
      idx_r <= '0;
      acc_r <= '0;
      hb_r  <= 1'b0;
      out_wait_r <= '0;
      case (in_operation)
        pqwt_pkg::OP_PUSH: begin
          out_head_r  <= '0;
          out_empty_r <= q_empty;
          out_full_r  <= q_full;
          out_drop_r  <= q_full;
        end
        pqwt_pkg::OP_POP: begin
          out_drop_r <= q_empty;
          if (q_empty) begin
            out_head_r  <= '0;
            out_empty_r <= 1'b1;
            out_full_r  <= q_full;
          end else begin
            out_head_r  <= slot_time_r[0];
            out_empty_r <= (occ_r == pqwt_pkg::OCC_W'(1));
            out_full_r  <= 1'b0;
            for (int k = 0; k < pqwt_pkg::QUEUE_DEPTH - 1; k++) begin
              slot_time_r[k] <= slot_time_r[k+1];
              slot_prio_r[k] <= slot_prio_r[k+1];
            end
          end
        end
        pqwt_pkg::OP_PEEK: begin
          out_drop_r  <= q_empty;
          out_head_r  <= q_empty ? '0 : slot_time_r[0];
          out_empty_r <= q_empty;
          out_full_r  <= q_full;
        end
        default: begin
          out_head_r  <= '0;
          out_empty_r <= q_empty;
          out_full_r  <= q_full;
          out_drop_r  <= 1'b0;
        end
      endcase
    end else if (cmd.step) begin
      acc_r <= acc_nxt;
      idx_r <= idx_r + pqwt_pkg::IDX_W'(1);
      if (idx_r == '0) hb_r <= (p_r < cur_prio);
    end else if (cmd.finish) begin
      if (idx_r == '0) begin
        slot_time_r[0] <= t_r;
        slot_prio_r[0] <= p_r;
      end
      for (int k = 1; k < pqwt_pkg::QUEUE_DEPTH; k++) begin
        if (k > int'(idx_r)) begin
          slot_time_r[k] <= slot_time_r[k-1];
          slot_prio_r[k] <= slot_prio_r[k-1];
        end else if (k == int'(idx_r)) begin
          slot_time_r[k] <= t_r;
          slot_prio_r[k] <= p_r;
        end
      end
      out_wait_r  <= acc_r;
      out_head_r  <= '0;
      out_empty_r <= 1'b0;
      out_full_r  <= (occ_inc == pqwt_pkg::OCC_W'(pqwt_pkg::QUEUE_DEPTH));
      out_drop_r  <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_wait_time = out_wait_r;
  assign out_head_time = out_head_r;
  assign out_is_empty  = out_empty_r;
  assign out_is_full   = out_full_r;
  assign out_dropped   = out_drop_r;

endmodule
`default_nettype wire

// File: rtl/pqwt_checker.sv
// Port-level checker for priority_queue_with_wait_time_top, bound to the top level.
// Depends on pqwt_pkg for widths and operation codes.
`default_nettype none
module pqwt_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic [1:0]                     in_operation,
  input wire logic                           out_valid,
  input wire logic [pqwt_pkg::WAIT_W-1:0]    out_wait_time,
  input wire logic [pqwt_pkg::TIME_BITS-1:0] out_head_time,
  input wire logic                           out_is_empty,
  input wire logic                           out_is_full,
  input wire logic                           out_dropped
);

  // non-push commands answer in the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != pqwt_pkg::OP_PUSH |=> out_valid)
    else $error("missing result after single-cycle command");

  a_no_result_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe during push scan");

  a_scan_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("push scan ended without result");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_wait_time == '0 && out_head_time == '0)
    else $error("dropped transfer carries nonzero times");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> !out_is_full)
    else $error("queue flagged empty and full");

endmodule

bind priority_queue_with_wait_time_top pqwt_checker u_pqwt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_operation  (in_operation),
  .out_valid     (out_valid),
  .out_wait_time (out_wait_time),
  .out_head_time (out_head_time),
  .out_is_empty  (out_is_empty),
  .out_is_full   (out_is_full),
  .out_dropped   (out_dropped)
);
`default_nettype wire

// File: sim/priority_queue_with_wait_time_top_test.sv
// Testbench for priority_queue_with_wait_time_top: directed table, then random bursts.
// Accepted commands are scored against a local scheduler model or a typed row.
// Depends on rtl/pqwt_pkg.sv and the block's RTL.
`timescale 1ns / 1ps
module priority_queue_with_wait_time_top_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM     = 1900;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = pqwt_pkg::QUEUE_DEPTH + 8;
  localparam int N_PLAN       = 24;

  typedef struct packed {
    logic [pqwt_pkg::WAIT_W-1:0]    wait_time;
    logic [pqwt_pkg::TIME_BITS-1:0] head_time;
    logic                           empty;
    logic                           full;
    logic                           dropped;
  } job_result_t;

  typedef struct packed {
    logic [1:0]                     op;
    logic [pqwt_pkg::TIME_BITS-1:0] svc;
    logic [pqwt_pkg::PRIO_BITS-1:0] prio;
    logic                           typed;
    job_result_t                    res;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [1:0]                     in_operation;
  logic [pqwt_pkg::TIME_BITS-1:0] in_service_time;
  logic [pqwt_pkg::PRIO_BITS-1:0] in_priority_req;
  logic                           out_valid;
  logic [pqwt_pkg::WAIT_W-1:0]    out_wait_time;
  logic [pqwt_pkg::TIME_BITS-1:0] out_head_time;
  logic                           out_is_empty;
  logic                           out_is_full;
  logic                           out_dropped;

  logic        row_typed;
  job_result_t row_res;

  logic [pqwt_pkg::TIME_BITS-1:0] sched_time [pqwt_pkg::QUEUE_DEPTH];
  logic [pqwt_pkg::PRIO_BITS-1:0] sched_prio [pqwt_pkg::QUEUE_DEPTH];
  int                             sched_count;
  job_result_t                    pending_q [$];

  int errors;
  int cycles;
  int n_cmds;
  int n_results;
  int n_full_refused;
  int n_empty_refused;
  int n_full_seen;

  plan_row_t plan [N_PLAN];

  priority_queue_with_wait_time_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_service_time (in_service_time),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_wait_time   (out_wait_time),
    .out_head_time   (out_head_time),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full),
    .out_dropped     (out_dropped)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Scheduler model: slot 0 is the job in service and is never displaced.
  function automatic job_result_t apply_command(
      input logic [1:0]                     op,
      input logic [pqwt_pkg::TIME_BITS-1:0] svc,
      input logic [pqwt_pkg::PRIO_BITS-1:0] prio);
    job_result_t r;
    int          pos;
    int          acc;
    r = '0;
    pos = 0;
    acc = 0;
    case (op)
      pqwt_pkg::OP_PUSH: begin
        if (sched_count >= pqwt_pkg::QUEUE_DEPTH) begin
          r.dropped = 1'b1;
        end else begin
          if (sched_count == 0) begin
            pos = 0;
          end else if (prio < sched_prio[0]) begin
            pos = 1;
          end else begin
            while (pos < sched_count && prio >= sched_prio[pos]) pos++;
          end
          for (int i = 0; i < pos; i++) begin
            acc += int'(sched_time[i]);
            if (acc > int'(pqwt_pkg::WAIT_MAX)) acc = int'(pqwt_pkg::WAIT_MAX);
          end
          for (int i = sched_count; i > pos; i--) begin
            sched_time[i] = sched_time[i-1];
            sched_prio[i] = sched_prio[i-1];
          end
          sched_time[pos] = svc;
          sched_prio[pos] = prio;
          sched_count++;
          r.wait_time = acc[pqwt_pkg::WAIT_W-1:0];
        end
      end
      pqwt_pkg::OP_POP, pqwt_pkg::OP_PEEK: begin
        if (sched_count == 0) begin
          r.dropped = 1'b1;
        end else begin
          r.head_time = sched_time[0];
          if (op == pqwt_pkg::OP_POP) begin
            for (int i = 0; i + 1 < sched_count; i++) begin
              sched_time[i] = sched_time[i+1];
              sched_prio[i] = sched_prio[i+1];
            end
            sched_count--;
          end
        end
      end
      default: begin
      end
    endcase
    r.empty = (sched_count == 0);
    r.full  = (sched_count >= pqwt_pkg::QUEUE_DEPTH);
    return r;
  endfunction

  always @(posedge clk) begin : scoreboard
    job_result_t want;
    job_result_t got;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, pending_q.size());
      $display("*** FAILED ***");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        got = '{out_wait_time, out_head_time, out_is_empty, out_is_full, out_dropped};
        n_results++;
        if (got.dropped && got.full) n_full_refused++;
        else if (got.dropped) n_empty_refused++;
        if (got.full) n_full_seen++;
        if (pending_q.size() == 0) begin
          $error("result transfer with nothing pending");
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got.wait_time !== want.wait_time) begin
            $error("wait_time: expected %0h, got %0h", want.wait_time, got.wait_time);
            errors++;
          end
          if (got.head_time !== want.head_time) begin
            $error("head_time: expected %0h, got %0h", want.head_time, got.head_time);
            errors++;
          end
          if (got.empty !== want.empty) begin
            $error("is_empty: expected %0b, got %0b", want.empty, got.empty);
            errors++;
          end
          if (got.full !== want.full) begin
            $error("is_full: expected %0b, got %0b", want.full, got.full);
            errors++;
          end
          if (got.dropped !== want.dropped) begin
            $error("dropped: expected %0b, got %0b", want.dropped, got.dropped);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_command(in_operation, in_service_time, in_priority_req);
        if (row_typed) want = row_res;
        pending_q.push_back(want);
        n_cmds++;
      end
    end
  end

  task automatic issue(input logic [1:0] op,
                       input logic [pqwt_pkg::TIME_BITS-1:0] svc,
                       input logic [pqwt_pkg::PRIO_BITS-1:0] prio, input logic typed,
                       input job_result_t res);
    @(negedge clk);
    start           = 1'b1;
    in_operation    = op;
    in_service_time = svc;
    in_priority_req = prio;
    row_typed       = typed;
    row_res         = res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  initial begin : stimulus
    int                             burst_left;
    int                             gap;
    int                             push_pct;
    int                             roll;
    logic [1:0]                     op;
    logic [pqwt_pkg::TIME_BITS-1:0] svc;
    logic [pqwt_pkg::PRIO_BITS-1:0] prio;

    plan = '{
      '{pqwt_pkg::OP_POP,  16'h0000, 8'h00, 1'b1, '{20'h0, 16'h0000, 1'b1, 1'b0, 1'b1}},
      '{pqwt_pkg::OP_PEEK, 16'h0000, 8'h00, 1'b1, '{20'h0, 16'h0000, 1'b1, 1'b0, 1'b1}},
      '{OP_UNUSED,         16'hFFFF, 8'hFF, 1'b1, '{20'h0, 16'h0000, 1'b1, 1'b0, 1'b0}},
      '{pqwt_pkg::OP_PUSH, 16'hFFFF, 8'h80, 1'b1, '{20'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
      '{pqwt_pkg::OP_PEEK, 16'h0000, 8'h00, 1'b1, '{20'h0, 16'hFFFF, 1'b0, 1'b0, 1'b0}},
      '{pqwt_pkg::OP_PUSH, 16'h0001, 8'h00, 1'b1, '{20'h0FFFF, 16'h0000, 1'b0, 1'b0, 1'b0}},
      '{pqwt_pkg::OP_PUSH, 16'h0000, 8'hFF, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h5555, 8'h80, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'hAAAA, 8'h55, 1'b0, '0},
      '{OP_UNUSED,         16'h0000, 8'h00, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h0001, 8'h01, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h8000, 8'h7F, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h7FFF, 8'h80, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h00FF, 8'hFE, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'hFF00, 8'h02, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h1234, 8'h40, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'hC3A5, 8'h10, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h0F0F, 8'hFF, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'hF0F0, 8'h00, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h3C3C, 8'h81, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'h0000, 8'hC0, 1'b0, '0},
      '{pqwt_pkg::OP_PUSH, 16'hFFFF, 8'h00, 1'b1, '{20'h0, 16'h0000, 1'b0, 1'b1, 1'b1}},
      '{OP_UNUSED,         16'h0000, 8'h00, 1'b1, '{20'h0, 16'h0000, 1'b0, 1'b1, 1'b0}},
      '{pqwt_pkg::OP_POP,  16'h0000, 8'h00, 1'b1, '{20'h0, 16'hFFFF, 1'b0, 1'b0, 1'b0}}
    };

    rst_n           = 1'b0;
    start           = 1'b0;
    in_operation    = pqwt_pkg::OP_PUSH;
    in_service_time = '0;
    in_priority_req = '0;
    row_typed       = 1'b0;
    row_res         = '0;
    sched_count     = 0;
    errors          = 0;
    cycles          = 0;
    n_cmds          = 0;
    n_results       = 0;
    n_full_refused  = 0;
    n_empty_refused = 0;
    n_full_seen     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int k = 0; k < N_PLAN; k++) begin
      issue(plan[k].op, plan[k].svc, plan[k].prio, plan[k].typed, plan[k].res);
    end

    // Push ratio swings between phases so the queue both fills and drains.
    push_pct   = 60;
    burst_left = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 50;
          default: push_pct = 25;
        endcase
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) begin
          gap = $urandom_range(1, 8);
          @(negedge clk);
          start     = 1'b0;
          row_typed = 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 3) op = OP_UNUSED;
      else if (roll < push_pct) op = pqwt_pkg::OP_PUSH;
      else if ($urandom_range(0, 3) == 0) op = pqwt_pkg::OP_PEEK;
      else op = pqwt_pkg::OP_POP;
      case ($urandom_range(0, 5))
        0:       svc = '0;
        1:       svc = '1;
        default: svc = pqwt_pkg::TIME_BITS'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       prio = '0;
        1:       prio = '1;
        2, 3:    prio = pqwt_pkg::PRIO_BITS'($urandom_range(0, 3));
        default: prio = pqwt_pkg::PRIO_BITS'($urandom);
      endcase
      issue(op, svc, prio, 1'b0, '0);
    end

    @(negedge clk);
    start     = 1'b0;
    row_typed = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d commands (%0d directed), checked %0d results in %0d cycles",
             n_cmds, N_PLAN, n_results, cycles);
    $display("Refused pushes on full queue: %0d, pops/peeks on empty: %0d, full flags: %0d",
             n_full_refused, n_empty_refused, n_full_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: priority_queue_with_wait_time_top.f
rtl/pqwt_pkg.sv
rtl/pqwt_ctrl.sv
rtl/pqwt_dp.sv
rtl/priority_queue_with_wait_time_top.sv
rtl/pqwt_checker.sv
sim/priority_queue_with_wait_time_top_test.sv
